FILE: rtl/core/ctl_pkg.sv
`timescale 1ns / 1ps
package ctl_pkg;
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DSET,
      ST_DIV,
      ST_EVAL,
      ST_OUT
   } state_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ERR  = 2'd1;
   localparam logic [1:0] STATUS_PREV = 2'd2;
   localparam logic [32:0] U32_MAX = 33'h0ffffffff;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic div_start;
      logic div_step;
      logic eval;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic last;
   } sts_type;
endpackage

FILE: rtl/core/ctl_ctrl.sv
`timescale 1ns / 1ps
module ctl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctl_pkg::cmd_type cmd,
   input  ctl_pkg::sts_type sts
);
   import ctl_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL;
         ST_MUL: if (sts.mul_done) state_in = sts.last ? ST_DSET : ST_EVAL;
         ST_DSET: state_in = ST_DIV;
         ST_DIV: if (sts.div_done) state_in = ST_EVAL;
         ST_EVAL: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_MUL: cmd.mul_step = 1'b1;
         // load the divider once the offset product is complete
         ST_DSET: cmd.div_start = 1'b1;
         ST_DIV: cmd.div_step = 1'b1;
         ST_EVAL: cmd.eval = 1'b1;
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

FILE: rtl/core/ctl_dp.sv
`timescale 1ns / 1ps
module ctl_dp #(
   parameter int OFFSET_BITS = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  ctl_pkg::cmd_type cmd,
   output ctl_pkg::sts_type sts,
   input  logic             csr_write_enable,
   input  logic [47:0]      csr_write_data,
   input  logic [11:0]      req_sector_bytes,
   input  logic             req_has_index_zero,
   input  logic [31:0]      req_index_zero_pos,
   input  logic             req_has_index_one,
   input  logic [31:0]      req_index_one_pos,
   input  logic [31:0]      req_extra_pregap,
   input  logic [31:0]      req_extra_postgap,
   input  logic [31:0]      req_next_begin_pos,
   input  logic             req_is_last_track,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_pregap_first_sector,
   output logic [31:0]      rsp_track_start_sector,
   output logic [31:0]      rsp_visible_pregap_len,
   output logic [47:0]      rsp_pregap_byte_offset,
   output logic [47:0]      rsp_start_byte_offset,
   output logic [31:0]      rsp_index_zero_logical,
   output logic [31:0]      rsp_track_end_sector,
   output logic [31:0]      rsp_track_data_sectors,
   output logic [47:0]      rsp_end_byte_offset,
   output logic [31:0]      rsp_image_end_sector,
   output logic [31:0]      rsp_total_sectors
);
   import ctl_pkg::*;

   localparam int OB = OFFSET_BITS;
   localparam int PB = OB + 12;
   localparam int CW = $clog2(OB + 1);

   logic [OB-1:0] fsize_ff, bcur_ff;
   logic [31:0]   lcur_ff;
   logic          first_ff, failed_ff;

   // latched request
   logic [11:0] ss_ff;
   logic        h0_ff, h1_ff, last_ff;
   logic [31:0] i0_ff, i1_ff, pre_ff, post_ff, nfb_ff;

   // shift-add multiplier: three products, 12-bit multiplicand
   logic [31:0] ma_ff, mb_ff, mc_ff;   // fb, fpg, fs multipliers
   logic [PB-1:0] pa_ff, pb_ff, pc_ff;
   logic [5:0]  mcnt_ff;

   // restoring divider
   logic [OB-1:0] q_ff;
   logic [12:0]   r_ff;
   logic [CW-1:0] dcnt_ff;

   logic [31:0] fb, fpg_w, fs_w;
   assign fb = req_has_index_zero ? req_index_zero_pos : req_index_one_pos;
   assign fpg_w = req_index_one_pos - fb;
   assign fs_w = req_next_begin_pos - fb;

   logic [31:0] fbl;
   assign fbl = h0_ff ? i0_ff : i1_ff;

   // offset for this track, remainder for divide
   logic [PB:0] off_w;
   assign off_w = first_ff ? {1'b0, pa_ff} : {{(PB-OB+1){1'b0}}, bcur_ff};
   logic [PB:0] remain_w;
   assign remain_w = {{(PB-OB+1){1'b0}}, fsize_ff} - off_w;

   assign sts.mul_done = mcnt_ff == 6'd31;
   assign sts.div_done = dcnt_ff == CW'(OB - 1);
   assign sts.last = last_ff;

   logic [12:0] rsh;
   assign rsh = {r_ff[11:0], q_ff[OB-1]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ss_ff <= req_sector_bytes;
         h0_ff <= req_has_index_zero;
         h1_ff <= req_has_index_one;
         last_ff <= req_is_last_track;
         i0_ff <= req_index_zero_pos;
         i1_ff <= req_index_one_pos;
         pre_ff <= req_extra_pregap;
         post_ff <= req_extra_postgap;
         nfb_ff <= req_next_begin_pos;
         ma_ff <= fb;
         mb_ff <= fpg_w;
         mc_ff <= fs_w;
         pa_ff <= '0;
         pb_ff <= '0;
         pc_ff <= '0;
         mcnt_ff <= '0;
      end else if (cmd.mul_step) begin
         // accumulate from the high multiplier bit down
         pa_ff <= (pa_ff << 1) + (ma_ff[31] ? PB'(ss_ff) : '0);
         pb_ff <= (pb_ff << 1) + (mb_ff[31] ? PB'(ss_ff) : '0);
         pc_ff <= (pc_ff << 1) + (mc_ff[31] ? PB'(ss_ff) : '0);
         ma_ff <= ma_ff << 1;
         mb_ff <= mb_ff << 1;
         mc_ff <= mc_ff << 1;
         mcnt_ff <= mcnt_ff + 6'd1;
      end
      if (cmd.div_start) begin
         q_ff <= remain_w[OB-1:0];
         r_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (rsh >= {1'b0, ss_ff}) begin
            r_ff <= rsh - {1'b0, ss_ff};
            q_ff <= {q_ff[OB-2:0], 1'b1};
         end else begin
            r_ff <= rsh;
            q_ff <= {q_ff[OB-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + CW'(1);
      end
   end

   // evaluate layout
   logic        err;
   logic [32:0] fpg, fs, ts, vp, start, endsec0, endsec, pos0;
   logic [PB:0] endoff, stoff;
   always_comb begin
      err = 1'b0;
      fpg = {1'b0, i1_ff} - {1'b0, fbl};
      if (first_ff && pa_ff > PB'(fsize_ff)) err = 1'b1;
      if (!h1_ff || ss_ff == '0) err = 1'b1;
      if (i1_ff < fbl) err = 1'b1;
      if (!last_ff) begin
         fs = {1'b0, nfb_ff} - {1'b0, fbl};
         endoff = off_w + {1'b0, pc_ff};
         if (nfb_ff <= fbl || nfb_ff < i1_ff) err = 1'b1;
         if (endoff > {{(PB-OB+1){1'b0}}, fsize_ff}) err = 1'b1;
      end else begin
         fs = q_ff[32:0];
         endoff = {{(PB-OB+1){1'b0}}, fsize_ff};
         if (off_w > {{(PB-OB+1){1'b0}}, fsize_ff}) err = 1'b1;
         if (r_ff != '0) err = 1'b1;
         if (OB > 32 && (q_ff >> 32) != '0) err = 1'b1;
      end
      if (fs <= fpg) err = 1'b1;
      ts = fs - fpg;
      if ({1'b0, pre_ff} > U32_MAX - fpg) err = 1'b1;
      vp = first_ff ? 33'd0 : {1'b0, pre_ff} + fpg;
      if (U32_MAX - {1'b0, lcur_ff} < vp) err = 1'b1;
      start = {1'b0, lcur_ff} + vp;
      pos0 = (!first_ff && h0_ff) ? {1'b0, lcur_ff} + {1'b0, pre_ff} : 33'd0;
      if (U32_MAX - start < ts - 33'd1) err = 1'b1;
      endsec0 = start + ts - 33'd1;
      if (U32_MAX - endsec0 < {1'b0, post_ff}) err = 1'b1;
      endsec = endsec0 + {1'b0, post_ff};
      if (endsec == U32_MAX || {1'b0, fbl} > U32_MAX - (fs - 33'd1)) err = 1'b1;
      stoff = off_w + {1'b0, pb_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsize_ff <= '0;
         bcur_ff <= '0;
         lcur_ff <= '0;
         first_ff <= 1'b1;
         failed_ff <= 1'b0;
      end else begin
         if (csr_write_enable) fsize_ff <= OB'(csr_write_data);
         if (cmd.eval && !failed_ff) begin
            if (err) failed_ff <= 1'b1;
            else begin
               lcur_ff <= endsec[31:0] + 32'd1;
               bcur_ff <= endoff[OB-1:0];
               first_ff <= 1'b0;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rsp_status <= failed_ff ? STATUS_PREV : (err ? STATUS_ERR : STATUS_OK);
         if (failed_ff || err) begin
            rsp_pregap_first_sector <= '0;
            rsp_track_start_sector <= '0;
            rsp_visible_pregap_len <= '0;
            rsp_pregap_byte_offset <= '0;
            rsp_start_byte_offset <= '0;
            rsp_index_zero_logical <= '0;
            rsp_track_end_sector <= '0;
            rsp_track_data_sectors <= '0;
            rsp_end_byte_offset <= '0;
            rsp_image_end_sector <= '0;
            rsp_total_sectors <= '0;
         end else begin
            rsp_pregap_first_sector <= lcur_ff;
            rsp_track_start_sector <= start[31:0];
            rsp_visible_pregap_len <= vp[31:0];
            rsp_pregap_byte_offset <= 48'(off_w);
            rsp_start_byte_offset <= 48'(stoff);
            rsp_index_zero_logical <= pos0[31:0];
            rsp_track_end_sector <= endsec[31:0];
            rsp_track_data_sectors <= ts[31:0];
            rsp_end_byte_offset <= 48'(endoff);
            rsp_image_end_sector <= fbl + fs[31:0] - 32'd1;
            rsp_total_sectors <= endsec[31:0] + 32'd1;
         end
      end
   end
endmodule

FILE: rtl/core/cue_track_layout_core.sv
`timescale 1ns / 1ps
// Cue track layout core: takes one track request at a time and returns its logical
// and byte layout, keeping running sector and byte cursors across requests. After a
// request is accepted, the three shift-add sector-size products are formed, then on
// the last track the serial remainder divide runs (one load step, then one step per
// quotient bit), and then the layout is evaluated into the result registers. The
// next request is accepted in the cycle after the result is taken. Errors are sticky
// until reset. Write image_file_bytes through csr_ only while idle.
module cue_track_layout_core #(
   parameter int OFFSET_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [47:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_sector_bytes,
   input  logic        req_has_index_zero,
   input  logic [31:0] req_index_zero_pos,
   input  logic        req_has_index_one,
   input  logic [31:0] req_index_one_pos,
   input  logic [31:0] req_extra_pregap,
   input  logic [31:0] req_extra_postgap,
   input  logic [31:0] req_next_begin_pos,
   input  logic        req_is_last_track,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_pregap_first_sector,
   output logic [31:0] rsp_track_start_sector,
   output logic [31:0] rsp_visible_pregap_len,
   output logic [47:0] rsp_pregap_byte_offset,
   output logic [47:0] rsp_start_byte_offset,
   output logic [31:0] rsp_index_zero_logical,
   output logic [31:0] rsp_track_end_sector,
   output logic [31:0] rsp_track_data_sectors,
   output logic [47:0] rsp_end_byte_offset,
   output logic [31:0] rsp_image_end_sector,
   output logic [31:0] rsp_total_sectors
);
   import ctl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ctl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .sts(sts)
   );

   ctl_dp #(.OFFSET_BITS(OFFSET_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_sector_bytes(req_sector_bytes), .req_has_index_zero(req_has_index_zero),
      .req_index_zero_pos(req_index_zero_pos), .req_has_index_one(req_has_index_one),
      .req_index_one_pos(req_index_one_pos), .req_extra_pregap(req_extra_pregap),
      .req_extra_postgap(req_extra_postgap), .req_next_begin_pos(req_next_begin_pos),
      .req_is_last_track(req_is_last_track), .rsp_status(rsp_status),
      .rsp_pregap_first_sector(rsp_pregap_first_sector),
      .rsp_track_start_sector(rsp_track_start_sector),
      .rsp_visible_pregap_len(rsp_visible_pregap_len),
      .rsp_pregap_byte_offset(rsp_pregap_byte_offset),
      .rsp_start_byte_offset(rsp_start_byte_offset),
      .rsp_index_zero_logical(rsp_index_zero_logical),
      .rsp_track_end_sector(rsp_track_end_sector),
      .rsp_track_data_sectors(rsp_track_data_sectors),
      .rsp_end_byte_offset(rsp_end_byte_offset),
      .rsp_image_end_sector(rsp_image_end_sector),
      .rsp_total_sectors(rsp_total_sectors)
   );
endmodule
